### rtl/core/gbte_pkg.sv
package gbte_pkg;

   localparam int FIELD_W = 11;
   localparam int CHAR_W  = 8;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_BACK   = 3'd1,
      CMD_LEFT   = 3'd2,
      CMD_RIGHT  = 3'd3,
      CMD_SETPOS = 3'd4,
      CMD_END    = 3'd5,
      CMD_CLEAR  = 3'd6,
      CMD_READ   = 3'd7
   } cmd_type;

   typedef enum logic {
      STATUS_DONE    = 1'b0,
      STATUS_REFUSED = 1'b1
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ
   } state_type;

   typedef struct packed {
      cmd_type             command;
      logic [CHAR_W-1:0]   char_in;
      logic [FIELD_W-1:0]  position;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [CHAR_W-1:0]   char_out;
      logic [FIELD_W-1:0]  cursor;
      logic [FIELD_W-1:0]  text_length;
   } rsp_type;

endpackage

### rtl/core/gbte_store.sv
module gbte_store
   import gbte_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/gap_buffer_text_engine.sv
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_payload  (command, char_in, position)
// rsp      out        rsp_valid/rsp_stall   rsp_payload  (status, char_out, cursor, text_length)
//
// Insert, backspace, clear and any refused command: result the cycle after the transfer.
// Read: the store read, then the result register. Left and right: one step through the store,
// then the result register. Set cursor and go end: one step per character the gap moves; the
// single read and single write port of the text store move one character a cycle.
// Reset clears the cursor and empties the text; the text store itself is not cleared.
// A command is taken only when the engine is idle and the result register is free or draining.
module gap_buffer_text_engine
   import gbte_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

   state_type         state_ff, state_in;
   logic [PW-1:0]     gs_ff, gs_in;
   logic [PW-1:0]     ge_ff, ge_in;
   logic [PW-1:0]     target_ff, target_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic              req_accept;
   logic              slot_free;
   logic              load;
   status_type        rsp_status;
   logic [CHAR_W-1:0] rsp_char;
   logic              ins_wr;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [CHAR_W-1:0] rd_data;
   logic              st_wr_en;
   logic [AW-1:0]     st_wr_addr;
   logic [CHAR_W-1:0] st_wr_data;

   logic [PW-1:0]     len_cur;
   logic [PW-1:0]     len_in;
   logic [PW-1:0]     gs_dec;
   logic [PW-1:0]     ge_dec;
   logic [PW-1:0]     gs_inc;
   logic [PW-1:0]     ge_inc;
   logic [CW-1:0]     pos_x;
   logic [CW-1:0]     len_x;
   logic [CW:0]       read_at;
   logic [CW-1:0]     cursor_x;
   logic [CW-1:0]     len_out_x;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !slot_free;
   assign req_accept = req_valid && !req_stall;

   assign len_cur = gs_ff + CAP_P - ge_ff;
   assign gs_dec  = gs_ff - PW'(1);
   assign ge_dec  = ge_ff - PW'(1);
   assign gs_inc  = gs_ff + PW'(1);
   assign ge_inc  = ge_ff + PW'(1);
   assign pos_x   = CW'(req_payload.position);
   assign len_x   = CW'(len_cur);

   // logical index to store address: skip the gap for indexes past the cursor
   assign read_at = (pos_x < CW'(gs_ff)) ? (CW+1)'(pos_x)
                                         : (CW+1)'(pos_x) + (CW+1)'(ge_ff - gs_ff);

   always_comb begin
      state_in   = state_ff;
      gs_in      = gs_ff;
      ge_in      = ge_ff;
      target_in  = target_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      rd_en      = 1'b0;
      rd_addr    = read_at[AW-1:0];
      ins_wr     = 1'b0;
      load       = 1'b0;
      rsp_status = STATUS_DONE;
      rsp_char   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               load = 1'b1;
               unique case (req_payload.command)
                  CMD_INSERT: begin
                     if (gs_ff < ge_ff) begin
                        ins_wr = 1'b1;
                        gs_in  = gs_inc;
                     end else begin
                        rsp_status = STATUS_REFUSED;
                     end
                  end
                  CMD_BACK: begin
                     if (gs_ff != '0) begin
                        gs_in = gs_dec;
                     end else begin
                        rsp_status = STATUS_REFUSED;
                     end
                  end
                  CMD_LEFT: begin
                     if (gs_ff != '0) begin
                        load      = 1'b0;
                        target_in = gs_dec;
                        state_in  = ST_WALK;
                     end else begin
                        rsp_status = STATUS_REFUSED;
                     end
                  end
                  CMD_RIGHT: begin
                     if (ge_ff != CAP_P) begin
                        load      = 1'b0;
                        target_in = gs_inc;
                        state_in  = ST_WALK;
                     end else begin
                        rsp_status = STATUS_REFUSED;
                     end
                  end
                  CMD_SETPOS: begin
                     if (pos_x <= len_x) begin
                        load      = 1'b0;
                        target_in = PW'(pos_x);
                        state_in  = ST_WALK;
                     end else begin
                        rsp_status = STATUS_REFUSED;
                     end
                  end
                  CMD_END: begin
                     load      = 1'b0;
                     target_in = len_cur;
                     state_in  = ST_WALK;
                  end
                  CMD_CLEAR: begin
                     ge_in = CAP_P;
                  end
                  CMD_READ: begin
                     if (pos_x < len_x) begin
                        load     = 1'b0;
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        rsp_status = STATUS_REFUSED;
                     end
                  end
                  default: begin
                     rsp_status = STATUS_REFUSED;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // one character a cycle: read now, write back the next cycle
            priority if (gs_ff < target_ff) begin
               rd_en      = 1'b1;
               rd_addr    = ge_ff[AW-1:0];
               wr_pend_in = 1'b1;
               wr_addr_in = gs_ff[AW-1:0];
               gs_in      = gs_inc;
               ge_in      = ge_inc;
            end else if (gs_ff > target_ff) begin
               rd_en      = 1'b1;
               rd_addr    = gs_dec[AW-1:0];
               wr_pend_in = 1'b1;
               wr_addr_in = ge_dec[AW-1:0];
               gs_in      = gs_dec;
               ge_in      = ge_dec;
            end else begin
               if (slot_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (slot_free) begin
               load     = 1'b1;
               rsp_char = rd_data;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign len_in    = gs_in + CAP_P - ge_in;
   assign cursor_x  = CW'(gs_in);
   assign len_out_x = CW'(len_in);

   always_comb begin
      rsp_payload_in.status      = rsp_status;
      rsp_payload_in.char_out    = rsp_char;
      rsp_payload_in.cursor      = cursor_x[FIELD_W-1:0];
      rsp_payload_in.text_length = len_out_x[FIELD_W-1:0];
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   // pending walk write has the port; inserts only happen while idle
   assign st_wr_en   = wr_pend_ff || ins_wr;
   assign st_wr_addr = wr_pend_ff ? wr_addr_ff : gs_ff[AW-1:0];
   assign st_wr_data = wr_pend_ff ? rd_data : req_payload.char_in;

   gbte_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gs_ff        <= '0;
         ge_ff        <= CAP_P;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gs_ff        <= gs_in;
         ge_ff        <= ge_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      wr_addr_ff <= wr_addr_in;
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gs_ff <= ge_ff)
      else $error("gap start beyond gap end");

   a_idle_no_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_pend_ff)
      else $error("write-back pending while idle");

   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |=> (len_cur == $past(len_cur)))
      else $error("text length changed during a walk");

   a_insert_adv: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.command == CMD_INSERT && gs_ff < ge_ff)
      |=> (gs_ff == $past(gs_inc)))
      else $error("insert did not advance the cursor");

endmodule

### tb/text_engine_checker.sv
`timescale 1ns / 1ps

module text_engine_checker
   import gbte_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      awaited
);

   // shadow of the editor: prefix in [0, gap_start), suffix in [gap_end, CAPACITY)
   logic [CHAR_W-1:0] text_mem [CAPACITY];
   int unsigned       gap_start;
   int unsigned       gap_end;
   rsp_type           pending_answers [$];
   int                bad_count;

   function automatic int unsigned text_length();
      return gap_start + (CAPACITY - gap_end);
   endfunction

   function automatic void gap_step_left();
      gap_start--;
      gap_end--;
      text_mem[gap_end] = text_mem[gap_start];
   endfunction

   function automatic void gap_step_right();
      text_mem[gap_start] = text_mem[gap_end];
      gap_start++;
      gap_end++;
   endfunction

   function automatic rsp_type apply_command(req_type cmd);
      rsp_type     answer;
      bit          refused;
      int unsigned target;
      int unsigned slot;
      answer  = '0;
      refused = 1'b0;
      target  = 32'(cmd.position);
      case (cmd.command)
         CMD_INSERT: begin
            if (gap_start < gap_end) begin
               text_mem[gap_start] = cmd.char_in;
               gap_start++;
            end else
               refused = 1'b1;
         end
         CMD_BACK: begin
            if (gap_start != 0) gap_start--;
            else refused = 1'b1;
         end
         CMD_LEFT: begin
            if (gap_start != 0) gap_step_left();
            else refused = 1'b1;
         end
         CMD_RIGHT: begin
            if (gap_end < CAPACITY) gap_step_right();
            else refused = 1'b1;
         end
         CMD_SETPOS: begin
            if (target > text_length())
               refused = 1'b1;
            else begin
               while (gap_start < target && gap_end < CAPACITY) gap_step_right();
               while (gap_start > target) gap_step_left();
            end
         end
         CMD_END: begin
            while (gap_end < CAPACITY) gap_step_right();
         end
         CMD_CLEAR: begin
            gap_end = CAPACITY;
         end
         default: begin
            if (target >= text_length())
               refused = 1'b1;
            else begin
               slot = (target < gap_start) ? target : target + (gap_end - gap_start);
               answer.char_out = text_mem[slot];
            end
         end
      endcase
      answer.status      = refused ? STATUS_REFUSED : STATUS_DONE;
      answer.cursor      = FIELD_W'(gap_start);
      answer.text_length = FIELD_W'(text_length());
      return answer;
   endfunction

   task automatic report_field(input string field, input logic [FIELD_W-1:0] exp_v,
                               input logic [FIELD_W-1:0] act_v);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
      bad_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         gap_start = 0;
         gap_end   = CAPACITY;
         foreach (text_mem[i]) text_mem[i] = '0;
         pending_answers.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_answers.push_back(apply_command(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected result transfer, got %h", $time, rsp_payload);
               bad_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_payload.status !== want.status)
                  report_field("status", FIELD_W'(want.status),
                               FIELD_W'(rsp_payload.status));
               if (rsp_payload.char_out !== want.char_out)
                  report_field("char_out", FIELD_W'(want.char_out),
                               FIELD_W'(rsp_payload.char_out));
               if (rsp_payload.cursor !== want.cursor)
                  report_field("cursor", want.cursor, rsp_payload.cursor);
               if (rsp_payload.text_length !== want.text_length)
                  report_field("text_length", want.text_length, rsp_payload.text_length);
            end
         end
      end
      awaited    <= pending_answers.size();
      fail_count <= bad_count;
   end

endmodule

### tb/gap_buffer_text_engine_tb.sv
`timescale 1ns / 1ps

module gap_buffer_text_engine_tb
   import gbte_pkg::*;
;

   localparam int CAPACITY    = 1024;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int LONG_HOLD   = 300;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int awaited;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;
   int cycles_run  = 0;

   int idle_plan  [4] = '{0, 69, 0, 23};
   int stall_plan [4] = '{0, 0, 69, 23};

   gap_buffer_text_engine #(.CAPACITY(CAPACITY)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   text_engine_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .awaited     (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_asked != holds_done) begin
         holds_done <= holds_done + 1;
         hold_left  <= LONG_HOLD;
         rsp_stall  <= 1'b1;
      end else
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // returns at the edge where the transfer happens
   task automatic issue(input cmd_type op, input logic [CHAR_W-1:0] ch,
                        input logic [FIELD_W-1:0] pos);
      req_type item;
      item.command  = op;
      item.char_in  = ch;
      item.position = pos;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic empty_text();
      issue(CMD_SETPOS, CHAR_W'($urandom_range(255)), '0);
      issue(CMD_CLEAR, CHAR_W'($urandom_range(255)), FIELD_W'($urandom_range(2047)));
   endtask

   task automatic random_edit();
      int unsigned           pick;
      cmd_type               op;
      logic [FIELD_W-1:0]    pos;
      pick = $urandom_range(99);
      if (pick < 28)      op = CMD_INSERT;
      else if (pick < 46) op = CMD_BACK;
      else if (pick < 56) op = CMD_LEFT;
      else if (pick < 66) op = CMD_RIGHT;
      else if (pick < 78) op = CMD_SETPOS;
      else if (pick < 82) op = CMD_END;
      else if (pick < 86) op = CMD_CLEAR;
      else                op = CMD_READ;
      if ($urandom_range(9) < 7) pos = FIELD_W'($urandom_range(48));
      else pos = FIELD_W'($urandom_range(2047));
      issue(op, CHAR_W'($urandom_range(255)), pos);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty buffer: boundaries and refusals
      issue(CMD_BACK, 8'h00, 11'd0);
      issue(CMD_LEFT, 8'hFF, 11'd2047);
      issue(CMD_RIGHT, 8'h00, 11'd0);
      issue(CMD_READ, 8'h00, 11'd0);
      issue(CMD_SETPOS, 8'h00, 11'd1);
      issue(CMD_SETPOS, 8'h00, 11'd0);
      issue(CMD_END, 8'h00, 11'd0);
      issue(CMD_CLEAR, 8'h00, 11'd0);
      issue(CMD_INSERT, 8'h00, 11'd0);
      issue(CMD_INSERT, 8'hFF, 11'd2047);
      issue(CMD_INSERT, 8'h41, 11'd0);
      issue(CMD_READ, 8'h00, 11'd0);
      issue(CMD_READ, 8'h00, 11'd2);
      issue(CMD_READ, 8'h00, 11'd3);
      issue(CMD_READ, 8'h00, 11'd2047);
      issue(CMD_LEFT, 8'h00, 11'd0);
      issue(CMD_LEFT, 8'h00, 11'd0);
      issue(CMD_READ, 8'h00, 11'd2);
      issue(CMD_RIGHT, 8'h00, 11'd0);
      issue(CMD_BACK, 8'h00, 11'd0);
      issue(CMD_INSERT, 8'h7E, 11'd0);
      issue(CMD_SETPOS, 8'h00, 11'd0);
      issue(CMD_END, 8'h00, 11'd0);
      issue(CMD_SETPOS, 8'h00, 11'd1);
      issue(CMD_CLEAR, 8'h00, 11'd0);
      issue(CMD_READ, 8'h00, 11'd1);
      issue(CMD_SETPOS, 8'h00, 11'd2047);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_plan[phase];
         stall_pct <= stall_plan[phase];
         empty_text();
         repeat (93) random_edit();
      end

      // long receiver hold-off while the sender keeps offering
      idle_pct  = 0;
      stall_pct <= 0;
      holds_asked <= holds_asked + 1;
      repeat (40) random_edit();
      empty_text();

      req_valid <= 1'b0;
      stall_pct <= 0;
      do @(posedge clock); while (awaited != 0);
      repeat (30) @(posedge clock);

      if (fail_count == 0 && awaited == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
rtl/core/gbte_pkg.sv
rtl/core/gbte_store.sv
rtl/core/gap_buffer_text_engine.sv
tb/text_engine_checker.sv
tb/gap_buffer_text_engine_tb.sv
